### design/braking_bounded_velocity_controller_core_macros.svh
// ============================================================================
// Assertion macros for the braking-bounded velocity controller
// Clocked assertion helpers for the checks inside the core.
// ============================================================================
`ifndef BRAKING_BOUNDED_VELOCITY_CONTROLLER_CORE_MACROS_SVH
`define BRAKING_BOUNDED_VELOCITY_CONTROLLER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define BBVC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define BBVC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### design/bbvc_pkg.sv
// ============================================================================
// Braking-bounded velocity controller package
// Payload types, register codes, reset values and the square root step.
// ============================================================================
package bbvc_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int GAIN_FRAC         = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_POSITION   = 3'd0,
      REG_POS_GAIN          = 3'd1,
      REG_DAMP_GAIN         = 3'd2,
      REG_TRACK_GAIN        = 3'd3,
      REG_BRAKE_DECEL       = 3'd4,
      REG_FORCE_SPEED_LIMIT = 3'd5,
      REG_MAX_SPEED         = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic signed [23:0] TARGET_POSITION_RST   = 24'sd0;
   localparam logic [23:0]        POS_GAIN_RST          = 24'd12800;
   localparam logic [23:0]        DAMP_GAIN_RST         = 24'd1280;
   localparam logic [23:0]        TRACK_GAIN_RST        = 24'd51200;
   localparam logic [23:0]        BRAKE_DECEL_RST       = 24'd7680;
   localparam logic [22:0]        FORCE_SPEED_LIMIT_RST = 23'd74146;
   localparam logic [22:0]        MAX_SPEED_RST         = 23'd65536;

   // Saturation limits
   localparam logic signed [23:0] CMD_MAX   = 24'sh7F_FFFF;
   localparam logic signed [31:0] DRIVE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DRIVE_MIN = 32'sh8000_0000;

   // Payloads
   typedef struct packed {
      logic signed [23:0] position;
      logic signed [23:0] velocity;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [23:0] speed_command;
      logic [22:0]        speed_bound;
      logic               clamped;
   } rsp_payload_type;

   // Square root unit: restoring, one result bit per step
   localparam int SQRT_RAD_W           = 64;
   localparam int SQRT_ROOT_W          = SQRT_RAD_W / 2;
   localparam int SQRT_REM_W           = SQRT_ROOT_W + 2;
   localparam int SQRT_STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES          = SQRT_ROOT_W / SQRT_STEPS_PER_STAGE;

   typedef struct packed {
      logic [SQRT_REM_W-1:0]  rem;
      logic [SQRT_ROOT_W-1:0] root;
      logic [SQRT_RAD_W-1:0]  rad;
   } sqrt_state_type;

   // Bring down the next radicand pair and try to set one more root bit
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      logic [SQRT_REM_W-1:0] acc;
      logic [SQRT_REM_W-1:0] trial;
      sqrt_state_type        r;
      acc   = {s.rem[SQRT_REM_W-3:0], s.rad[SQRT_RAD_W-1 -: 2]};
      trial = {s.root, 2'b01};
      r.rad = {s.rad[SQRT_RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
         r.rem  = acc - trial;
         r.root = {s.root[SQRT_ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = acc;
         r.root = {s.root[SQRT_ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### design/braking_bounded_velocity_controller_core.sv
// ============================================================================
// Braking-bounded velocity controller core
// PD speed command, clamped on approach by the braking, force and maximum
// speed bounds, followed by a velocity-tracking drive output.
// ============================================================================
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------
//   req     | in        | req_valid / req_ready | position, velocity
//   rsp     | out       | rsp_valid / rsp_ready | drive, command, bound, clamped
//   csr     | in        | csr_write_enable      | csr_index, csr_write_data
//
// Every stage, square root stages included, is registered; a new transaction
// enters every cycle while the response side keeps taking. The square root has
// eight stages, four root bits a stage. Reset clears all valid bits and loads
// the register defaults. A stalled response freezes the whole pipeline;
// nothing is lost or repeated.
//
`include "braking_bounded_velocity_controller_core_macros.svh"

module braking_bounded_velocity_controller_core #(
   parameter int FRAC_BITS = bbvc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bbvc_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bbvc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [bbvc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bbvc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import bbvc_pkg::*;

   localparam int PROD_W     = 50;
   localparam int RPROD_W    = 47;
   localparam int RAW_W      = 51;
   localparam int VDES_W     = RAW_W - GAIN_FRAC;
   localparam int DRV_W      = PROD_W - GAIN_FRAC;
   localparam int RAD_SHIFT  = FRAC_BITS - GAIN_FRAC + 1;
   localparam int ROUND_HALF = 1 << (GAIN_FRAC - 1);

   // Configuration registers
   logic signed [23:0] target_position_ff;
   logic [23:0]        pos_gain_ff;
   logic [23:0]        damp_gain_ff;
   logic [23:0]        track_gain_ff;
   logic [23:0]        brake_decel_ff;
   logic [22:0]        force_speed_limit_ff;
   logic [22:0]        max_speed_ff;

   // Pipeline control
   logic adv;

   // Stage 1: position error
   logic               s1_valid_ff;
   logic signed [24:0] s1_err_ff, s1_err_in;
   logic [22:0]        s1_posp_ff, s1_posp_in;
   logic signed [23:0] s1_vel_ff;

   // Stage 2: products
   logic                      s2_valid_ff;
   logic signed [PROD_W-1:0]  s2_p1_ff, s2_p1_in;
   logic signed [PROD_W-1:0]  s2_p2_ff, s2_p2_in;
   logic [RPROD_W-1:0]        s2_pr_ff, s2_pr_in;
   logic signed [23:0]        s2_vel_ff;

   // Stage 3: rounded command and radicand
   logic                      s3_valid_ff;
   logic signed [RAW_W-1:0]   s3_raw_rnd;
   logic signed [VDES_W-1:0]  s3_vdes_ff, s3_vdes_in;
   logic [SQRT_RAD_W-1:0]     s3_rad_ff, s3_rad_in;
   logic signed [23:0]        s3_vel_ff;

   // Square root stages
   sqrt_state_type           sqrt_seed;
   sqrt_state_type           sq_state_ff [SQRT_STAGES];
   logic signed [VDES_W-1:0] sq_vdes_ff  [SQRT_STAGES];
   logic signed [23:0]       sq_vel_ff   [SQRT_STAGES];
   logic                     sq_valid_ff [SQRT_STAGES];

   // Stage 4: bound and clamp
   logic [SQRT_ROOT_W-1:0]   s4_brake;
   logic [22:0]              s4_min_ms;
   logic signed [VDES_W:0]   s4_margin;
   logic signed [23:0]       s4_neg_bound;
   logic                     s4_ovf;
   logic                     s4_valid_ff;
   logic [22:0]              s4_bound_ff, s4_bound_in;
   logic                     s4_clamped_ff, s4_clamped_in;
   logic signed [23:0]       s4_cmd_ff, s4_cmd_in;
   logic signed [23:0]       s4_vel_ff;

   // Stage 5: drive product
   logic signed [24:0]       s5_diff;
   logic                     s5_valid_ff;
   logic signed [PROD_W-1:0] s5_prod_ff, s5_prod_in;
   logic signed [23:0]       s5_cmd_ff;
   logic [22:0]              s5_bound_ff;
   logic                     s5_clamped_ff;

   // Output stage
   logic signed [PROD_W-1:0] s6_rnd;
   logic signed [DRV_W-1:0]  s6_drv;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   // Write configuration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_position_ff   <= TARGET_POSITION_RST;
         pos_gain_ff          <= POS_GAIN_RST;
         damp_gain_ff         <= DAMP_GAIN_RST;
         track_gain_ff        <= TRACK_GAIN_RST;
         brake_decel_ff       <= BRAKE_DECEL_RST;
         force_speed_limit_ff <= FORCE_SPEED_LIMIT_RST;
         max_speed_ff         <= MAX_SPEED_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_TARGET_POSITION:   target_position_ff   <= csr_write_data;
            REG_POS_GAIN:          pos_gain_ff          <= csr_write_data;
            REG_DAMP_GAIN:         damp_gain_ff         <= csr_write_data;
            REG_TRACK_GAIN:        track_gain_ff        <= csr_write_data;
            REG_BRAKE_DECEL:       brake_decel_ff       <= csr_write_data;
            REG_FORCE_SPEED_LIMIT: force_speed_limit_ff <= csr_write_data[22:0];
            REG_MAX_SPEED:         max_speed_ff         <= csr_write_data[22:0];
            default: ;
         endcase
      end
   end

   // Advance every stage unless the output register holds a stalled response
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: error and positive part of position
   assign s1_err_in  = 25'(req_payload.position) - 25'(target_position_ff);
   assign s1_posp_in = (!req_payload.position[23] && (req_payload.position != '0)) ?
                       req_payload.position[22:0] : '0;

   // Stage 2: gain products
   assign s2_p1_in = PROD_W'($signed({1'b0, pos_gain_ff})) * PROD_W'(s1_err_ff);
   assign s2_p2_in = PROD_W'($signed({1'b0, damp_gain_ff})) * PROD_W'(s1_vel_ff);
   assign s2_pr_in = RPROD_W'(brake_decel_ff) * RPROD_W'(s1_posp_ff);

   // Stage 3: negate, round half up, scale the radicand
   assign s3_raw_rnd = RAW_W'(ROUND_HALF) - RAW_W'(s2_p1_ff) - RAW_W'(s2_p2_ff);
   assign s3_vdes_in = s3_raw_rnd[RAW_W-1:GAIN_FRAC];
   assign s3_rad_in  = SQRT_RAD_W'(s2_pr_ff) << RAD_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_err_ff  <= s1_err_in;
         s1_posp_ff <= s1_posp_in;
         s1_vel_ff  <= req_payload.velocity;
         s2_p1_ff   <= s2_p1_in;
         s2_p2_ff   <= s2_p2_in;
         s2_pr_ff   <= s2_pr_in;
         s2_vel_ff  <= s1_vel_ff;
         s3_vdes_ff <= s3_vdes_in;
         s3_rad_ff  <= s3_rad_in;
         s3_vel_ff  <= s2_vel_ff;
      end
   end

   // Square root: each stage resolves four root bits
   assign sqrt_seed = '{rem: '0, root: '0, rad: s3_rad_ff};

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      sqrt_state_type           prev_state;
      logic signed [VDES_W-1:0] prev_vdes;
      logic signed [23:0]       prev_vel;
      logic                     prev_valid;
      sqrt_state_type           stage_in;

      if (g == 0) begin : g_head
         assign prev_state = sqrt_seed;
         assign prev_vdes  = s3_vdes_ff;
         assign prev_vel   = s3_vel_ff;
         assign prev_valid = s3_valid_ff;
      end else begin : g_body
         assign prev_state = sq_state_ff[g-1];
         assign prev_vdes  = sq_vdes_ff[g-1];
         assign prev_vel   = sq_vel_ff[g-1];
         assign prev_valid = sq_valid_ff[g-1];
      end

      always_comb begin
         stage_in = prev_state;
         for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
            stage_in = sqrt_step(stage_in);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[g] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_state_ff[g] <= stage_in;
            sq_vdes_ff[g]  <= prev_vdes;
            sq_vel_ff[g]   <= prev_vel;
         end
      end
   end

   // Stage 4: smallest bound, clamp the approaching command, saturate high side
   assign s4_brake  = sq_state_ff[SQRT_STAGES-1].root;
   assign s4_min_ms = (SQRT_ROOT_W'(max_speed_ff) < s4_brake) ? max_speed_ff :
                      s4_brake[22:0];
   assign s4_bound_in = (force_speed_limit_ff < s4_min_ms) ? force_speed_limit_ff :
                        s4_min_ms;
   assign s4_margin = (VDES_W+1)'(sq_vdes_ff[SQRT_STAGES-1]) +
                      (VDES_W+1)'($signed({1'b0, s4_bound_in}));
   assign s4_clamped_in = s4_margin[VDES_W];
   assign s4_neg_bound  = 24'(0) - 24'({1'b0, s4_bound_in});
   // Unclamped command is above minus the bound, so only the top can overflow
   assign s4_ovf = !sq_vdes_ff[SQRT_STAGES-1][VDES_W-1] &&
                   (sq_vdes_ff[SQRT_STAGES-1][VDES_W-2:23] != '0);
   assign s4_cmd_in = s4_clamped_in ? s4_neg_bound :
                      (s4_ovf ? CMD_MAX : sq_vdes_ff[SQRT_STAGES-1][23:0]);

   // Stage 5: tracking error times gain
   assign s5_diff    = 25'(s4_cmd_ff) - 25'(s4_vel_ff);
   assign s5_prod_in = PROD_W'($signed({1'b0, track_gain_ff})) * PROD_W'(s5_diff);

   // Output stage: round and saturate the drive
   assign s6_rnd = s5_prod_ff + PROD_W'(ROUND_HALF);
   assign s6_drv = s6_rnd[PROD_W-1:GAIN_FRAC];

   always_comb begin
      rsp_payload_in.speed_command = s5_cmd_ff;
      rsp_payload_in.speed_bound   = s5_bound_ff;
      rsp_payload_in.clamped       = s5_clamped_ff;
      if (s6_drv[DRV_W-1:31] == '0 || s6_drv[DRV_W-1:31] == '1) begin
         rsp_payload_in.drive = s6_drv[31:0];
      end else if (s6_drv[DRV_W-1]) begin
         rsp_payload_in.drive = DRIVE_MIN;
      end else begin
         rsp_payload_in.drive = DRIVE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff  <= sq_valid_ff[SQRT_STAGES-1];
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_bound_ff    <= s4_bound_in;
         s4_clamped_ff  <= s4_clamped_in;
         s4_cmd_ff      <= s4_cmd_in;
         s4_vel_ff      <= sq_vel_ff[SQRT_STAGES-1];
         s5_prod_ff     <= s5_prod_in;
         s5_cmd_ff      <= s4_cmd_ff;
         s5_bound_ff    <= s4_bound_ff;
         s5_clamped_ff  <= s4_clamped_ff;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks
   `BBVC_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")
   `BBVC_ASSERT(a_accept_enters_pipe, (req_valid && req_ready) |=> s1_valid_ff,
                "accepted transaction missing from first stage")
   `BBVC_ASSERT(a_stall_freezes_sqrt,
                (rsp_valid && !rsp_ready) |=> $stable(sq_valid_ff[0]) && $stable(s4_cmd_ff),
                "pipeline moved during a stalled response")
   `BBVC_ASSERT(a_clamp_hits_bound,
                (rsp_valid && rsp_payload.clamped) |->
                (rsp_payload.speed_command == 24'(0) - 24'({1'b0, rsp_payload.speed_bound})),
                "clamped command differs from minus the bound")
   `BBVC_ASSERT(a_free_above_bound,
                (rsp_valid && !rsp_payload.clamped) |->
                (25'(rsp_payload.speed_command) +
                 $signed({2'b00, rsp_payload.speed_bound}) >= 25'sd0),
                "unclamped command below minus the bound")

endmodule

### bench/tb.sv
// ============================================================================
// Braking-bounded velocity controller testbench
// Drives position and velocity samples into the core under random burst and
// back-pressure patterns. It predicts each response from a local copy of the
// control law and register set, and compares every response field by field.
// ============================================================================
module tb;
   import bbvc_pkg::*;

   typedef longint unsigned u64_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   localparam int FRAC_BITS       = FRAC_BITS_DEFAULT;
   localparam int REG_COUNT       = 7;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_SAMPLES   = 123;
   localparam int STALL_PHASE     = 2;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int IDLE_LIMIT      = 3000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam logic signed [23:0]     POS_MAX      = 24'sh7F_FFFF;
   localparam logic signed [23:0]     POS_MIN      = 24'sh80_0000;
   localparam logic signed [23:0]     ONE_METRE    = 24'sh01_0000;
   localparam longint                 CMD_MIN      = -longint'(CMD_MAX) - 1;
   localparam longint                 ROUND_HALF   = longint'(1) << (GAIN_FRAC - 1);

   // DUT connections, all inputs known from time zero
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload      = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // Local copy of the register set
   logic signed [23:0] cfg_target      = TARGET_POSITION_RST;
   logic [23:0]        cfg_pos_gain    = POS_GAIN_RST;
   logic [23:0]        cfg_damp_gain   = DAMP_GAIN_RST;
   logic [23:0]        cfg_track_gain  = TRACK_GAIN_RST;
   logic [23:0]        cfg_decel       = BRAKE_DECEL_RST;
   logic [22:0]        cfg_force_limit = FORCE_SPEED_LIMIT_RST;
   logic [22:0]        cfg_max_speed   = MAX_SPEED_RST;

   logic [CSR_DATA_W-1:0] reg_plan [REG_COUNT];

   req_payload_type samples_q[$];
   rsp_payload_type outputs_q[$];

   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   int          burst_left     = 1;
   int          gap_left       = 0;
   int          hold_left      = 0;
   int          segment_left   = 0;
   int unsigned ready_tick     = 0;
   int unsigned ready_period   = 2;
   rx_mode_type rx_mode        = RX_STEADY;
   logic        stall_request  = 1'b0;
   logic        stall_taken    = 1'b0;

   braking_bounded_velocity_controller_core #(
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Floor square root, one root bit at a time from the top
   function automatic u64_type isqrt_floor(input u64_type n);
      u64_type root;
      u64_type trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (u64_type'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // Control law: PD command, approach clamp, tracking drive
   function automatic rsp_payload_type control_law(input req_payload_type sample);
      longint          pos;
      longint          vel;
      longint          raw;
      longint          vdes;
      longint          cmd;
      longint          drv;
      u64_type         radicand;
      u64_type         limit;
      rsp_payload_type r;
      pos = sample.position;
      vel = sample.velocity;
      raw = -(longint'(cfg_pos_gain) * (pos - longint'(cfg_target)))
            - longint'(cfg_damp_gain) * vel;
      vdes = (raw + ROUND_HALF) >>> GAIN_FRAC;

      // braking speed from the radicand in twice the fraction bits
      radicand = 0;
      if (pos > 0)
         radicand = (u64_type'(2) * u64_type'(cfg_decel) * u64_type'(pos))
                    << (2 * FRAC_BITS - (FRAC_BITS + GAIN_FRAC));
      limit = isqrt_floor(radicand);
      if (u64_type'(cfg_max_speed) < limit) limit = u64_type'(cfg_max_speed);
      if (u64_type'(cfg_force_limit) < limit) limit = u64_type'(cfg_force_limit);

      r.clamped = 1'b0;
      if (vdes < -longint'(limit)) begin
         vdes      = -longint'(limit);
         r.clamped = 1'b1;
      end
      cmd = vdes;
      if (cmd > longint'(CMD_MAX)) cmd = longint'(CMD_MAX);
      if (cmd < CMD_MIN) cmd = CMD_MIN;

      drv = (longint'(cfg_track_gain) * (cmd - vel) + ROUND_HALF) >>> GAIN_FRAC;
      if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);
      if (drv < longint'(DRIVE_MIN)) drv = longint'(DRIVE_MIN);

      r.drive         = drv[31:0];
      r.speed_command = cmd[23:0];
      r.speed_bound   = limit[22:0];
      return r;
   endfunction

   // Mirror a register write; unmapped indexes are dropped
   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_TARGET_POSITION:   cfg_target      = data;
         REG_POS_GAIN:          cfg_pos_gain    = data;
         REG_DAMP_GAIN:         cfg_damp_gain   = data;
         REG_TRACK_GAIN:        cfg_track_gain  = data;
         REG_BRAKE_DECEL:       cfg_decel       = data;
         REG_FORCE_SPEED_LIMIT: cfg_force_limit = data[22:0];
         REG_MAX_SPEED:         cfg_max_speed   = data[22:0];
         default: ;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      apply_reg(idx, data);
   endtask

   // Write the whole plan, with one stray write to the unmapped index
   task automatic program_settings();
      int unmapped_at;
      unmapped_at = $urandom_range(REG_COUNT, 0);
      for (int i = 0; i < REG_COUNT; i++) begin
         if (i == unmapped_at) write_reg(REG_UNMAPPED, CSR_DATA_W'($urandom));
         write_reg(csr_index_type'(i), reg_plan[i]);
      end
      if (unmapped_at == REG_COUNT) write_reg(REG_UNMAPPED, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random register value: zero, all ones, edges, full range or near reset
   function automatic logic [CSR_DATA_W-1:0] pick_setting(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] dflt;
      int unsigned           base;
      int unsigned           roll;
      logic [31:0]           offs;
      case (idx)
         REG_TARGET_POSITION:   dflt = TARGET_POSITION_RST;
         REG_POS_GAIN:          dflt = POS_GAIN_RST;
         REG_DAMP_GAIN:         dflt = DAMP_GAIN_RST;
         REG_TRACK_GAIN:        dflt = TRACK_GAIN_RST;
         REG_BRAKE_DECEL:       dflt = BRAKE_DECEL_RST;
         REG_FORCE_SPEED_LIMIT: dflt = CSR_DATA_W'(FORCE_SPEED_LIMIT_RST);
         default:               dflt = CSR_DATA_W'(MAX_SPEED_RST);
      endcase
      base = 32'(dflt);
      roll = $urandom_range(9, 0);
      case (roll)
         0:       return '0;
         1:       return 24'hFF_FFFF;
         2:       return 24'h7F_FFFF;
         3:       return 24'h80_0000;
         4, 5:    return CSR_DATA_W'($urandom);
         default: begin
            if (idx == REG_TARGET_POSITION) begin
               offs = $urandom_range(393216, 0) - 196608;
               return offs[23:0];
            end
            return CSR_DATA_W'($urandom_range(base * 4, base / 4));
         end
      endcase
   endfunction

   // Random sample field: near zero, full range or an extreme
   function automatic logic [23:0] pick_field();
      logic [31:0] offs;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: begin
            offs = $urandom_range(393216, 0) - 196608;
            return offs[23:0];
         end
         4: begin
            case ($urandom_range(4, 0))
               0:       return POS_MAX;
               1:       return POS_MIN;
               2:       return 24'd1;
               3:       return 24'hFF_FFFF;
               default: return '0;
            endcase
         end
         default: return 24'($urandom);
      endcase
   endfunction

   // Field extremes, sign boundaries and an approach that hits the bound
   task automatic queue_directed();
      @(negedge clock);
      samples_q.push_back('{position: 24'sd0,  velocity: 24'sd0});
      samples_q.push_back('{position: 24'sd1,  velocity: -24'sd1});
      samples_q.push_back('{position: -24'sd1, velocity: 24'sd1});
      samples_q.push_back('{position: POS_MAX, velocity: POS_MIN});
      samples_q.push_back('{position: POS_MIN, velocity: POS_MAX});
      samples_q.push_back('{position: POS_MIN, velocity: POS_MIN});
      samples_q.push_back('{position: ONE_METRE, velocity: 24'sd0});
      samples_q.push_back('{position: POS_MAX, velocity: POS_MAX});
   endtask

   task automatic queue_random(input int count);
      req_payload_type sample;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         sample.position = pick_field();
         sample.velocity = pick_field();
         samples_q.push_back(sample);
      end
   endtask

   // Hold off until every queued sample has been answered
   task automatic drain();
      @(negedge clock);
      while (samples_q.size() != 0 || outputs_q.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : p_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) outputs_q.push_back(control_law(req_payload));
         offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (samples_q.size() != 0) begin
            req_payload <= samples_q.pop_front();
            offer = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(64, 1);
               gap_left   = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(12, 1);
            end
         end
         req_valid <= offer;
      end
   end

   // Receiver: segments of steady, light, heavy or periodic stalls
   always @(posedge clock) begin : p_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_request && !stall_taken) begin
         stall_taken = 1'b1;
         hold_left   = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(200, 20);
            rx_mode      = rx_mode_type'($urandom_range(3, 0));
            ready_period = $urandom_range(8, 2);
         end
         segment_left--;
         ready_tick++;
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_LIGHT:  rsp_ready <= ($urandom_range(9, 0) < 8);
            RX_HEAVY:  rsp_ready <= ($urandom_range(9, 0) < 3);
            default:   rsp_ready <= (ready_tick % ready_period == 0);
         endcase
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin : p_monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outputs_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected response drive %0d command %0d bound %0d clamped %0b",
                        $realtime, rsp_payload.drive, rsp_payload.speed_command,
                        rsp_payload.speed_bound, rsp_payload.clamped);
         end else begin
            want = outputs_q.pop_front();
            if (rsp_payload.drive !== want.drive ||
                rsp_payload.speed_command !== want.speed_command ||
                rsp_payload.speed_bound !== want.speed_bound ||
                rsp_payload.clamped !== want.clamped) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp drive %0d cmd %0d bound %0d clamped %0b, %s",
                           $realtime, want.drive, want.speed_command, want.speed_bound,
                           want.clamped,
                           $sformatf("got drive %0d cmd %0d bound %0d clamped %0b",
                                     rsp_payload.drive, rsp_payload.speed_command,
                                     rsp_payload.speed_bound, rsp_payload.clamped));
            end
         end
      end
   end

   // Watchdog: abort when no transaction moves for too long
   always @(posedge clock) begin : p_watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : p_main
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset values first
      queue_directed();
      drain();

      // every register at its top end
      reg_plan[REG_TARGET_POSITION]   = 24'h7F_FFFF;
      reg_plan[REG_POS_GAIN]          = 24'hFF_FFFF;
      reg_plan[REG_DAMP_GAIN]         = 24'hFF_FFFF;
      reg_plan[REG_TRACK_GAIN]        = 24'hFF_FFFF;
      reg_plan[REG_BRAKE_DECEL]       = 24'hFF_FFFF;
      reg_plan[REG_FORCE_SPEED_LIMIT] = 24'h7F_FFFF;
      reg_plan[REG_MAX_SPEED]         = 24'h7F_FFFF;
      program_settings();
      queue_directed();
      drain();

      // everything zero, target at the bottom
      reg_plan[REG_TARGET_POSITION]   = 24'h80_0000;
      reg_plan[REG_POS_GAIN]          = '0;
      reg_plan[REG_DAMP_GAIN]         = '0;
      reg_plan[REG_TRACK_GAIN]        = '0;
      reg_plan[REG_BRAKE_DECEL]       = '0;
      reg_plan[REG_FORCE_SPEED_LIMIT] = '0;
      reg_plan[REG_MAX_SPEED]         = '0;
      program_settings();
      queue_directed();
      drain();

      // random settings, one phase with a long response hold-off
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < REG_COUNT; i++)
            reg_plan[i] = pick_setting(csr_index_type'(i));
         program_settings();
         queue_random(PHASE_SAMPLES);
         if (p == STALL_PHASE) stall_request = 1'b1;
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/bbvc_pkg.sv
design/braking_bounded_velocity_controller_core.sv
bench/tb.sv
